[rtl/core/pip_pkg.sv]
`timescale 1ns / 1ps

package pip_pkg;

   // operation codes of an input word
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_LOAD  = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;

   // register index of fill_enabled within the csr word address
   localparam logic REG_FILL_ENABLED = 1'b0;

   // integer bits of a coordinate (sign included) and the box reset bound
   localparam int INT_BITS    = 10;
   localparam int BOX_DEGREES = 500;

   // edge unit handshake
   typedef struct packed {
      logic start;
   } edge_ctl_type;

   typedef struct packed {
      logic done;
      logic crosses;
   } edge_sts_type;

endpackage

[rtl/core/pip_edge_unit.sv]
`timescale 1ns / 1ps

module pip_edge_unit #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  pip_pkg::edge_ctl_type        ctl,
   input  logic signed [COORD_BITS-1:0] x,
   input  logic signed [COORD_BITS-1:0] y,
   input  logic signed [COORD_BITS-1:0] ax,
   input  logic signed [COORD_BITS-1:0] ay,
   input  logic signed [COORD_BITS-1:0] bx,
   input  logic signed [COORD_BITS-1:0] by,
   output pip_pkg::edge_sts_type        sts
);
   import pip_pkg::*;

   localparam int MW = COORD_BITS + 1;
   localparam int PW = 2 * MW;
   localparam int AW = PW + 1;

   localparam logic [2:0] STEP_LAST_MUL = 3'd5;
   localparam logic [2:0] STEP_EVAL     = 3'd7;

   logic signed [COORD_BITS-1:0] x_ff, y_ff, ax_ff, ay_ff;
   logic signed [MW-1:0]         dx_ff, dy_ff;
   logic [2:0]                   step_ff, step_in;
   logic                         run_ff, run_in;
   logic signed [PW-1:0]         prod_ff, prod_in;
   logic signed [AW-1:0]         n_ff, n_in, d_ff, d_in, t_ff, t_in;
   edge_sts_type                 sts_ff, sts_in;

   logic signed [MW-1:0] op_a, op_b;
   logic signed [AW-1:0] prod_ext;

   // true when v / dd lies strictly between 0 and 1
   function automatic logic strictly_inside(input logic signed [AW-1:0] v,
                                            input logic signed [AW-1:0] dd);
      logic r;
      r = 1'b0;
      if (dd > 0) begin
         r = (v > 0) && (v < dd);
      end else if (dd < 0) begin
         r = (v < 0) && (dd < v);
      end
      return r;
   endfunction

   // operand selection for the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (step_ff)
         3'd0: begin op_a = MW'(ay_ff); op_b = MW'(x_ff);  end
         3'd1: begin op_a = MW'(ax_ff); op_b = MW'(y_ff);  end
         3'd2: begin op_a = MW'(y_ff);  op_b = dx_ff;      end
         3'd3: begin op_a = MW'(x_ff);  op_b = dy_ff;      end
         3'd4: begin op_a = MW'(ay_ff); op_b = dx_ff;      end
         3'd5: begin op_a = MW'(ax_ff); op_b = dy_ff;      end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   assign prod_ext = AW'(prod_ff);

   // sequencer, product register and accumulation
   always_comb begin
      step_in = step_ff;
      run_in  = run_ff;
      prod_in = prod_ff;
      n_in    = n_ff;
      d_in    = d_ff;
      t_in    = t_ff;
      sts_in  = '0;
      if (run_ff) begin
         if (step_ff <= STEP_LAST_MUL) begin
            prod_in = op_a * op_b;
         end
         case (step_ff)
            3'd1: n_in = prod_ext;
            3'd2: n_in = n_ff - prod_ext;
            3'd3: d_in = prod_ext;
            3'd4: d_in = d_ff - prod_ext;
            3'd5: t_in = prod_ext;
            3'd6: t_in = t_ff - prod_ext;
            default: ;
         endcase
         if (step_ff == STEP_EVAL) begin
            run_in         = 1'b0;
            sts_in.done    = 1'b1;
            sts_in.crosses = strictly_inside(n_ff, d_ff) && strictly_inside(t_ff, d_ff);
         end else begin
            step_in = step_ff + 3'd1;
         end
      end else if (ctl.start) begin
         run_in  = 1'b1;
         step_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
         sts_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         step_ff <= step_in;
         sts_ff  <= sts_in;
      end
   end

   // operand capture and arithmetic registers
   always_ff @(posedge clock) begin
      if (!run_ff && ctl.start) begin
         x_ff  <= x;
         y_ff  <= y;
         ax_ff <= ax;
         ay_ff <= ay;
         dx_ff <= MW'(bx) - MW'(ax);
         dy_ff <= MW'(by) - MW'(ay);
      end
      prod_ff <= prod_in;
      n_ff    <= n_in;
      d_ff    <= d_in;
      t_ff    <= t_in;
   end

   assign sts = sts_ff;

endmodule

[rtl/core/point_in_polygon_hit_tracker.sv]
`timescale 1ns / 1ps

// channel   direction  ports                      handshake
// request   in         start, busy, req_*         taken when start & !busy
// result    out        rsp_valid, rsp_*           one cycle strobe, no stall
// csr       in/out     psel ... pready            apb write on access cycle
//
// a vertex load is a read-modify-write of the polygon record. a query steps
// through the polygon slots and ends with an end check; each valid polygon has
// its record read, each whose box holds the point has its edges walked, and
// each edge takes six products from the single multiplier. busy is high for
// the whole item. synchronous reset clears control state and valid bits; the
// vertex store is not cleared. results cannot be stalled and are shown for
// one cycle.

module point_in_polygon_hit_tracker #(
   parameter int MAX_POLYGONS = 64,
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS   = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [1:0]                   req_op,
   input  logic [5:0]                   req_polygon_index,
   input  logic [7:0]                   req_vertex_index,
   input  logic signed [COORD_BITS-1:0] req_lon,
   input  logic signed [COORD_BITS-1:0] req_lat,
   input  logic [5:0]                   req_region,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   output logic                         rsp_hit,
   output logic [5:0]                   rsp_hit_polygon,
   output logic [5:0]                   rsp_hit_region,
   output logic                         rsp_region_changed,
   output logic                         rsp_left_all,
   output logic                         rsp_highlight_valid,
   output logic                         rsp_unhighlight_valid,
   output logic [5:0]                   rsp_unhighlight_region,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [2:0]                   paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import pip_pkg::*;

   localparam int PIW    = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int CW     = $clog2(MAX_VERTICES + 1);
   localparam int VDEPTH = MAX_POLYGONS * MAX_VERTICES;
   localparam int VAW    = $clog2(VDEPTH);
   localparam logic signed [COORD_BITS-1:0] BOX_LIMIT =
      COORD_BITS'(BOX_DEGREES) << (COORD_BITS - INT_BITS);
   localparam logic signed [COORD_BITS-1:0] BOX_NEG = -BOX_LIMIT;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_LOAD_RD   = 4'd1;
   localparam logic [3:0] S_LOAD_WR   = 4'd2;
   localparam logic [3:0] S_CLEAR     = 4'd3;
   localparam logic [3:0] S_Q_START   = 4'd4;
   localparam logic [3:0] S_P_SEL     = 4'd5;
   localparam logic [3:0] S_P_CHECK   = 4'd6;
   localparam logic [3:0] S_V_FIRST   = 4'd7;
   localparam logic [3:0] S_V_FETCH   = 4'd8;
   localparam logic [3:0] S_EDGE_GO   = 4'd9;
   localparam logic [3:0] S_EDGE_WAIT = 4'd10;
   localparam logic [3:0] S_RESULT    = 4'd11;

   logic [3:0]                   state_ff, state_in;
   logic                         fill_ff;
   logic [PIW-1:0]               p_idx_ff;
   logic [VW-1:0]                vi_ff;
   logic signed [COORD_BITS-1:0] lon_ff, lat_ff;
   logic [5:0]                   item_region_ff;
   logic                         last_ff;
   logic [PIW:0]                 k_ff, k_in;
   logic [CW-1:0]                j_ff, j_in, n_ff, n_in;
   logic                         parity_ff, parity_in;
   logic                         hit_ff, hit_in;
   logic                         ready_ff, ready_in;
   logic [5:0]                   hit_region_ff, hit_region_in;
   logic signed [COORD_BITS-1:0] prev_lon_ff, prev_lat_ff;
   logic                         cur_valid_ff, cur_valid_in;
   logic [5:0]                   cur_region_ff, cur_region_in;
   logic [MAX_POLYGONS-1:0]      used_ff, used_in, valid_ff, valid_in;

   // vertex store and polygon records
   logic [2*COORD_BITS-1:0]      vtx_mem [VDEPTH];
   logic [2*COORD_BITS-1:0]      vtx_q_ff;
   logic signed [COORD_BITS-1:0] lon_min_mem [MAX_POLYGONS];
   logic signed [COORD_BITS-1:0] lon_max_mem [MAX_POLYGONS];
   logic signed [COORD_BITS-1:0] lat_min_mem [MAX_POLYGONS];
   logic signed [COORD_BITS-1:0] lat_max_mem [MAX_POLYGONS];
   logic [CW-1:0]                count_mem   [MAX_POLYGONS];
   logic [5:0]                   region_mem  [MAX_POLYGONS];
   logic signed [COORD_BITS-1:0] lon_min_q_ff, lon_max_q_ff, lat_min_q_ff, lat_max_q_ff;
   logic [CW-1:0]                count_q_ff;
   logic [5:0]                   region_q_ff;
   logic                         used_q_ff;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_hit_ff, rsp_changed_ff, rsp_left_ff;
   logic                         rsp_high_ff, rsp_unhigh_ff;
   logic [5:0]                   rsp_poly_ff, rsp_region_ff, rsp_unregion_ff;
   logic                         r_hit, r_changed, r_left, r_high, r_unhigh;
   logic [5:0]                   r_poly, r_region, r_unregion;

   logic                         accept;
   logic                         cfg_write;
   logic [PIW-1:0]               k_idx;
   logic [PIW-1:0]               poly_addr;
   logic [VAW-1:0]               vtx_rd_addr, vtx_wr_addr;
   logic                         vtx_we, poly_we;
   logic signed [COORD_BITS-1:0] old_lon_min, old_lon_max, old_lat_min, old_lat_max;
   logic signed [COORD_BITS-1:0] new_lon_min, new_lon_max, new_lat_min, new_lat_max;
   logic                         in_box;
   logic [CW:0]                  j_next;
   edge_ctl_type                 edge_ctl;
   edge_sts_type                 edge_sts;

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;
   assign prdata    = (paddr[2] == REG_FILL_ENABLED) ? 32'(fill_ff) : 32'd0;

   assign k_idx       = k_ff[PIW-1:0];
   assign poly_addr   = (state_ff == S_LOAD_RD) ? p_idx_ff : k_idx;
   assign vtx_rd_addr = VAW'(k_idx) * VAW'(MAX_VERTICES) + VAW'(j_ff[VW-1:0]);
   assign vtx_wr_addr = VAW'(p_idx_ff) * VAW'(MAX_VERTICES) + VAW'(vi_ff);
   assign vtx_we      = (state_ff == S_LOAD_RD);
   assign poly_we     = (state_ff == S_LOAD_WR);
   assign j_next      = {1'b0, j_ff} + (CW+1)'(1);

   // polygon record as read, with reset values for a slot not loaded since clear
   assign old_lon_min = used_q_ff ? lon_min_q_ff : BOX_LIMIT;
   assign old_lon_max = used_q_ff ? lon_max_q_ff : BOX_NEG;
   assign old_lat_min = used_q_ff ? lat_min_q_ff : BOX_LIMIT;
   assign old_lat_max = used_q_ff ? lat_max_q_ff : BOX_NEG;

   // box widened by the loaded vertex
   assign new_lon_min = (lon_ff < old_lon_min) ? lon_ff : old_lon_min;
   assign new_lon_max = (old_lon_max < lon_ff) ? lon_ff : old_lon_max;
   assign new_lat_min = (lat_ff < old_lat_min) ? lat_ff : old_lat_min;
   assign new_lat_max = (old_lat_max < lat_ff) ? lat_ff : old_lat_max;

   // strict box test of the query point
   assign in_box = (old_lon_min < lon_ff) && (lon_ff < old_lon_max) &&
                   (old_lat_min < lat_ff) && (lat_ff < old_lat_max);

   assign edge_ctl.start = (state_ff == S_EDGE_GO);

   pip_edge_unit #(
      .COORD_BITS(COORD_BITS)
   ) u_edge (
      .clock(clock),
      .reset(reset),
      .ctl  (edge_ctl),
      .x    (lon_ff),
      .y    (lat_ff),
      .ax   (prev_lon_ff),
      .ay   (prev_lat_ff),
      .bx   (vtx_q_ff[COORD_BITS-1:0]),
      .by   (vtx_q_ff[2*COORD_BITS-1:COORD_BITS]),
      .sts  (edge_sts)
   );

   // result word and region tracking
   always_comb begin
      r_hit         = 1'b0;
      r_poly        = '0;
      r_region      = '0;
      r_changed     = 1'b0;
      r_left        = 1'b0;
      r_high        = 1'b0;
      r_unhigh      = 1'b0;
      r_unregion    = '0;
      cur_valid_in  = cur_valid_ff;
      cur_region_in = cur_region_ff;
      if (ready_ff) begin
         if (hit_ff) begin
            r_hit    = 1'b1;
            r_poly   = 6'(k_ff);
            r_region = hit_region_ff;
            if (!cur_valid_ff || (cur_region_ff != hit_region_ff)) begin
               r_changed = 1'b1;
               r_high    = fill_ff;
               if (cur_valid_ff && fill_ff) begin
                  r_unhigh   = 1'b1;
                  r_unregion = cur_region_ff;
               end
               cur_valid_in  = 1'b1;
               cur_region_in = hit_region_ff;
            end
         end else if (cur_valid_ff) begin
            r_changed = 1'b1;
            r_left    = 1'b1;
            if (fill_ff) begin
               r_unhigh   = 1'b1;
               r_unregion = cur_region_ff;
            end
            cur_valid_in = 1'b0;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      n_in          = n_ff;
      parity_in     = parity_ff;
      hit_in        = hit_ff;
      ready_in      = ready_ff;
      hit_region_in = hit_region_ff;
      used_in       = used_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_op)
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_LOAD: begin
                     if ((int'(req_polygon_index) < MAX_POLYGONS) &&
                         (int'(req_vertex_index) < MAX_VERTICES)) begin
                        state_in = S_LOAD_RD;
                     end
                  end
                  OP_QUERY: state_in = S_Q_START;
                  default: ;
               endcase
            end
         end
         S_CLEAR: begin
            used_in  = '0;
            valid_in = '0;
            state_in = S_IDLE;
         end
         S_LOAD_RD: state_in = S_LOAD_WR;
         S_LOAD_WR: begin
            used_in[p_idx_ff] = 1'b1;
            if (last_ff) begin
               valid_in[p_idx_ff] = 1'b1;
            end
            state_in = S_IDLE;
         end
         S_Q_START: begin
            hit_in = 1'b0;
            k_in   = '0;
            if (|valid_ff) begin
               ready_in = 1'b1;
               state_in = S_P_SEL;
            end else begin
               ready_in = 1'b0;
               state_in = S_RESULT;
            end
         end
         S_P_SEL: begin
            j_in = '0;
            if (k_ff == (PIW+1)'(MAX_POLYGONS)) begin
               state_in = S_RESULT;
            end else if (valid_ff[k_idx]) begin
               state_in = S_P_CHECK;
            end else begin
               k_in = k_ff + (PIW+1)'(1);
            end
         end
         S_P_CHECK: begin
            n_in          = used_q_ff ? count_q_ff : '0;
            hit_region_in = region_q_ff;
            parity_in     = 1'b0;
            if (in_box && (lon_ff != '0) && used_q_ff && (count_q_ff > CW'(1))) begin
               state_in = S_V_FIRST;
            end else begin
               k_in     = k_ff + (PIW+1)'(1);
               state_in = S_P_SEL;
            end
         end
         S_V_FIRST: begin
            j_in     = CW'(1);
            state_in = S_V_FETCH;
         end
         S_V_FETCH: state_in = S_EDGE_GO;
         S_EDGE_GO: state_in = S_EDGE_WAIT;
         S_EDGE_WAIT: begin
            if (edge_sts.done) begin
               parity_in = parity_ff ^ edge_sts.crosses;
               if (j_next < {1'b0, n_ff}) begin
                  j_in     = j_next[CW-1:0];
                  state_in = S_V_FETCH;
               end else if (parity_ff ^ edge_sts.crosses) begin
                  hit_in   = 1'b1;
                  state_in = S_RESULT;
               end else begin
                  k_in     = k_ff + (PIW+1)'(1);
                  state_in = S_P_SEL;
               end
            end
         end
         S_RESULT: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         fill_ff       <= 1'b0;
         used_ff       <= '0;
         valid_ff      <= '0;
         cur_valid_ff  <= 1'b0;
         cur_region_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         k_ff          <= '0;
         j_ff          <= '0;
         n_ff          <= '0;
         parity_ff     <= 1'b0;
         hit_ff        <= 1'b0;
         ready_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
         k_ff         <= k_in;
         j_ff         <= j_in;
         n_ff         <= n_in;
         parity_ff    <= parity_in;
         hit_ff       <= hit_in;
         ready_ff     <= ready_in;
         if (state_ff == S_RESULT) begin
            cur_valid_ff  <= cur_valid_in;
            cur_region_ff <= cur_region_in;
         end
         if (cfg_write && (paddr[2] == REG_FILL_ENABLED)) begin
            fill_ff <= pwdata[0];
         end
      end
   end

   // item capture, walk data and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         p_idx_ff       <= PIW'(req_polygon_index);
         vi_ff          <= VW'(req_vertex_index);
         lon_ff         <= req_lon;
         lat_ff         <= req_lat;
         item_region_ff <= req_region;
         last_ff        <= req_last_vertex;
      end
      hit_region_ff <= hit_region_in;
      if (state_ff == S_V_FIRST || state_ff == S_EDGE_GO) begin
         prev_lon_ff <= vtx_q_ff[COORD_BITS-1:0];
         prev_lat_ff <= vtx_q_ff[2*COORD_BITS-1:COORD_BITS];
      end
      if (state_ff == S_RESULT) begin
         rsp_hit_ff      <= r_hit;
         rsp_poly_ff     <= r_poly;
         rsp_region_ff   <= r_region;
         rsp_changed_ff  <= r_changed;
         rsp_left_ff     <= r_left;
         rsp_high_ff     <= r_high;
         rsp_unhigh_ff   <= r_unhigh;
         rsp_unregion_ff <= r_unregion;
      end
   end

   // vertex store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[vtx_wr_addr] <= {lat_ff, lon_ff};
      end
      vtx_q_ff <= vtx_mem[vtx_rd_addr];
   end

   // polygon records, read-modify-write on load
   always_ff @(posedge clock) begin
      if (poly_we) begin
         lon_min_mem[p_idx_ff] <= new_lon_min;
         lon_max_mem[p_idx_ff] <= new_lon_max;
         lat_min_mem[p_idx_ff] <= new_lat_min;
         lat_max_mem[p_idx_ff] <= new_lat_max;
         count_mem[p_idx_ff]   <= CW'(vi_ff) + CW'(1);
         region_mem[p_idx_ff]  <= item_region_ff;
      end
      lon_min_q_ff <= lon_min_mem[poly_addr];
      lon_max_q_ff <= lon_max_mem[poly_addr];
      lat_min_q_ff <= lat_min_mem[poly_addr];
      lat_max_q_ff <= lat_max_mem[poly_addr];
      count_q_ff   <= count_mem[poly_addr];
      region_q_ff  <= region_mem[poly_addr];
      used_q_ff    <= used_ff[poly_addr];
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_hit                = rsp_hit_ff;
   assign rsp_hit_polygon        = rsp_poly_ff;
   assign rsp_hit_region         = rsp_region_ff;
   assign rsp_region_changed     = rsp_changed_ff;
   assign rsp_left_all           = rsp_left_ff;
   assign rsp_highlight_valid    = rsp_high_ff;
   assign rsp_unhighlight_valid  = rsp_unhigh_ff;
   assign rsp_unhighlight_region = rsp_unregion_ff;

endmodule

[bench/point_in_polygon_hit_tracker_tb.sv]
`timescale 1ns / 1ps

module point_in_polygon_hit_tracker_tb;
   import pip_pkg::*;

   localparam int          NPOLY      = 64;
   localparam int          NVERT      = 256;
   localparam int          FRAC       = 32 - INT_BITS;
   localparam longint      BOX_BOUND  = longint'(BOX_DEGREES) <<< FRAC;
   localparam logic [1:0]  OP_UNUSED  = 2'd3;
   localparam int          DRAIN_WAIT = 40;
   localparam int          STALL_MAX  = 200000;

   typedef struct {
      logic [1:0]         op;
      logic [5:0]         poly;
      logic [7:0]         vidx;
      logic signed [31:0] lon;
      logic signed [31:0] lat;
      logic [5:0]         region;
      logic               last;
   } word_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] hit_polygon;
      logic [5:0] hit_region;
      logic       region_changed;
      logic       left_all;
      logic       highlight;
      logic       unhighlight;
      logic [5:0] unhighlight_region;
   } hit_report_type;

   logic clock, reset, start, busy;
   logic [1:0]  req_op;
   logic [5:0]  req_polygon_index, req_region;
   logic [7:0]  req_vertex_index;
   logic signed [31:0] req_lon, req_lat;
   logic req_last_vertex;
   logic rsp_valid, rsp_hit, rsp_region_changed, rsp_left_all;
   logic rsp_highlight_valid, rsp_unhighlight_valid;
   logic [5:0] rsp_hit_polygon, rsp_hit_region, rsp_unhighlight_region;
   logic psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   point_in_polygon_hit_tracker DUT (.*);

   // clock
   always begin
      clock = 1'b1; #10;
      clock = 1'b0; #10;
   end

   // predictor state
   longint vertex_lon [NPOLY][NVERT];
   longint vertex_lat [NPOLY][NVERT];
   longint lon_lo [NPOLY], lon_hi [NPOLY], lat_lo [NPOLY], lat_hi [NPOLY];
   int     path_len [NPOLY];
   logic [5:0] slot_region [NPOLY];
   bit     slot_valid [NPOLY];
   int     region_now;
   bit     fill_on;

   // stimulus-side bookkeeping
   word_type       words_pending [$];
   hit_report_type reports_due [$];
   int          written_upto [NPOLY];
   bit          shape_known [NPOLY];
   int          shape_cx [NPOLY], shape_cy [NPOLY], shape_w [NPOLY], shape_h [NPOLY];
   int          sender_idle_pct;
   int          errors;
   int          quiet_cycles;
   bit          handed;
   word_type    cur_word;

   function automatic bit strictly_between(logic signed [127:0] v, logic signed [127:0] d);
      if (d > 0) return v > 0 && v < d;
      if (d < 0) return v < 0 && v > d;
      return 1'b0;
   endfunction

   // crossing of the origin-to-point segment with edge a-b, exact
   function automatic bit edge_crossed(longint x, longint y, longint ax, longint ay,
                                       longint bx, longint by);
      logic signed [127:0] qx, qy, x1, y1, dx, dy, n, d, t;
      qx = x; qy = y; x1 = ax; y1 = ay;
      dx = bx - ax; dy = by - ay;
      n = y1 * qx - x1 * qy;
      d = qy * dx - qx * dy;
      t = y1 * dx - x1 * dy;
      return strictly_between(n, d) && strictly_between(t, d);
   endfunction

   function automatic void wipe_slots();
      for (int k = 0; k < NPOLY; k++) begin
         lon_lo[k] = BOX_BOUND;  lat_lo[k] = BOX_BOUND;
         lon_hi[k] = -BOX_BOUND; lat_hi[k] = -BOX_BOUND;
         path_len[k] = 0; slot_region[k] = '0; slot_valid[k] = 1'b0;
      end
   endfunction

   // update the polygon table for one word and queue the report a query makes
   function automatic void track_word(word_type w);
      longint         lon, lat;
      int             hitp, crossings;
      bit             any;
      hit_report_type r;
      int             p;
      lon = longint'(w.lon);
      lat = longint'(w.lat);
      p = w.poly;
      r = '{default: '0};
      hitp = -1;
      any = 1'b0;
      case (w.op)
         OP_CLEAR: wipe_slots();
         OP_LOAD: begin
            vertex_lon[p][w.vidx] = lon;
            vertex_lat[p][w.vidx] = lat;
            path_len[p] = int'(w.vidx) + 1;
            if (lon < lon_lo[p]) lon_lo[p] = lon;
            if (lon > lon_hi[p]) lon_hi[p] = lon;
            if (lat < lat_lo[p]) lat_lo[p] = lat;
            if (lat > lat_hi[p]) lat_hi[p] = lat;
            slot_region[p] = w.region;
            if (w.last) slot_valid[p] = 1'b1;
         end
         OP_QUERY: begin
            for (int k = 0; k < NPOLY; k++) any |= slot_valid[k];
            if (any) begin
               for (int k = 0; k < NPOLY && hitp < 0; k++) begin
                  if (!slot_valid[k]) continue;
                  if (!(lon_lo[k] < lon && lon < lon_hi[k] &&
                        lat_lo[k] < lat && lat < lat_hi[k])) continue;
                  if (lon == 0) continue;
                  crossings = 0;
                  for (int j = 0; j + 1 < path_len[k]; j++)
                     if (edge_crossed(lon, lat, vertex_lon[k][j], vertex_lat[k][j],
                                      vertex_lon[k][j+1], vertex_lat[k][j+1]))
                        crossings++;
                  if (crossings % 2 == 1) hitp = k;
               end
               if (hitp >= 0) begin
                  r.hit = 1'b1;
                  r.hit_polygon = 6'(hitp);
                  r.hit_region = slot_region[hitp];
                  if (int'(slot_region[hitp]) != region_now) begin
                     r.region_changed = 1'b1;
                     if (region_now >= 0 && fill_on) begin
                        r.unhighlight = 1'b1;
                        r.unhighlight_region = 6'(region_now);
                     end
                     region_now = slot_region[hitp];
                     r.highlight = fill_on;
                  end
               end else if (region_now >= 0) begin
                  r.region_changed = 1'b1;
                  r.left_all = 1'b1;
                  if (fill_on) begin
                     r.unhighlight = 1'b1;
                     r.unhighlight_region = 6'(region_now);
                  end
                  region_now = -1;
               end
            end
            reports_due.push_back(r);
         end
         default: ;
      endcase
   endfunction

   // acceptance, result checking and watchdog
   always @(posedge clock) begin
      hit_report_type exp_r, got;
      if (!reset) begin
         quiet_cycles++;
         if (rsp_valid) begin
            quiet_cycles = 0;
            got = '{rsp_hit, rsp_hit_polygon, rsp_hit_region, rsp_region_changed,
                    rsp_left_all, rsp_highlight_valid, rsp_unhighlight_valid,
                    rsp_unhighlight_region};
            if (reports_due.size() == 0) begin
               errors++;
               $display("%0t: result word with nothing expected", $time);
            end else begin
               exp_r = reports_due.pop_front();
               if (got !== exp_r) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
               end
            end
         end
         if (start && !busy) begin
            quiet_cycles = 0;
            track_word(cur_word);
            handed = 1'b1;
         end
         if (quiet_cycles >= STALL_MAX) begin
            $display("FAIL point_in_polygon_hit_tracker");
            $finish;
         end
      end
   end

   // request driver
   always @(negedge clock) begin
      word_type w;
      if (reset) begin
         start <= 1'b0;
      end else if (handed || !start) begin
         handed = 1'b0;
         if (words_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            w = words_pending.pop_front();
            cur_word = w;
            req_op <= w.op; req_polygon_index <= w.poly; req_vertex_index <= w.vidx;
            req_lon <= w.lon; req_lat <= w.lat; req_region <= w.region;
            req_last_vertex <= w.last;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic push_word(logic [1:0] op, int p, int vi, int lon, int lat,
                            int reg_no, bit last);
      word_type w;
      w = '{op, 6'(p), 8'(vi), 32'(lon), 32'(lat), 6'(reg_no), last};
      words_pending.push_back(w);
   endtask

   // closed path around a jittered rectangle, first vertex repeated at the end
   task automatic push_polygon(int p, int reg_no, int n, int cx, int cy, int w, int h,
                               bit close_it);
      int sx [4] = '{-1, 1, 1, -1};
      int sy [4] = '{-1, -1, 1, 1};
      int q, x0, y0, x, y;
      for (int i = 0; i < n - 1; i++) begin
         q = i * 4 / (n - 1);
         x = cx + sx[q] * w + int'($urandom_range(w / 2)) - w / 4;
         y = cy + sy[q] * h + int'($urandom_range(h / 2)) - h / 4;
         if (i == 0) begin x0 = x; y0 = y; end
         push_word(OP_LOAD, p, i, x, y, reg_no, 1'b0);
      end
      push_word(OP_LOAD, p, n - 1, x0, y0, reg_no, close_it);
      if (n > written_upto[p]) written_upto[p] = n;
      shape_known[p] = 1'b1;
      shape_cx[p] = cx; shape_cy[p] = cy; shape_w[p] = w; shape_h[p] = h;
   endtask

   task automatic csr_write(logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= 3'(REG_FILL_ENABLED) << 2; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      fill_on = value[0];
   endtask

   task automatic drain();
      wait (words_pending.size() == 0 && !start && reports_due.size() == 0 && !busy);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // random mix: mostly closed polygons and queries near them, some noise
   task automatic random_phase(int n_words);
      int made, r, p, vi, x, y;
      made = 0;
      while (made < n_words) begin
         r = $urandom_range(99);
         if (r < 3) begin
            push_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            for (int k = 0; k < NPOLY; k++) shape_known[k] = 1'b0;
            made++;
         end else if (r < 6) begin
            push_word(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom);
         end else if (r < 26) begin
            p = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(7);
            vi = $urandom_range(5, 9);
            push_polygon(p, $urandom_range(63), vi, int'($urandom) >>> 2,
                         int'($urandom) >>> 2, $urandom_range(1 << 10, 1 << 26),
                         $urandom_range(1 << 10, 1 << 26), $urandom_range(9) != 0);
            made += vi;
         end else if (r < 31) begin
            p = $urandom_range(7);
            if (written_upto[p] > 0) begin
               vi = $urandom_range(written_upto[p] - 1);
               push_word(OP_LOAD, p, vi, $urandom, $urandom, $urandom_range(63), $urandom);
               made++;
            end
         end else begin
            p = $urandom_range(63);
            if ($urandom_range(9) < 7 && shape_known[p]) begin
               x = shape_cx[p] + int'($urandom_range(2 * shape_w[p])) - shape_w[p];
               y = shape_cy[p] + int'($urandom_range(2 * shape_h[p])) - shape_h[p];
            end else begin
               x = ($urandom_range(19) == 0) ? 0 : $urandom;
               y = $urandom;
            end
            push_word(OP_QUERY, 0, 0, x, y, 0, 0);
            made++;
         end
      end
   endtask

   initial begin
      errors = 0; quiet_cycles = 0; handed = 1'b0; region_now = -1; fill_on = 1'b0;
      sender_idle_pct = 0;
      for (int k = 0; k < NPOLY; k++) begin
         written_upto[k] = 0; shape_known[k] = 1'b0;
      end
      wipe_slots();
      reset = 1'b1; start = 1'b0;
      req_op = OP_CLEAR; req_polygon_index = '0; req_vertex_index = '0;
      req_lon = '0; req_lat = '0; req_region = '0; req_last_vertex = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      csr_write(32'd1);
      // directed: empty table, ignored op, far vertex index
      push_word(OP_QUERY, 0, 0, 1000, 1000, 0, 0);
      push_word(OP_UNUSED, 63, 255, -1, -1, 63, 1);
      push_word(OP_LOAD, 62, 255, 32'h7fffffff, 32'h80000000, 63, 0);
      push_word(OP_CLEAR, 63, 255, -1, -1, 63, 1);
      // triangle with an edge lying on a line through the origin
      push_word(OP_LOAD, 2, 0, 1 << 20, 1 << 20, 9, 0);
      push_word(OP_LOAD, 2, 1, 3 << 20, 1 << 20, 9, 0);
      push_word(OP_LOAD, 2, 2, 3 << 20, 3 << 20, 9, 0);
      push_word(OP_LOAD, 2, 3, 1 << 20, 1 << 20, 9, 1);
      written_upto[2] = 4;
      push_word(OP_QUERY, 0, 0, 5 << 19, 3 << 19, 0, 0);
      push_word(OP_QUERY, 0, 0, 5 << 19, 3 << 19, 0, 0);
      push_word(OP_QUERY, 0, 0, 5 << 19, 5 << 19, 0, 0);
      push_word(OP_QUERY, 0, 0, 5 << 19, 3 << 19, 0, 0);
      // polygon spanning the full coordinate range
      push_word(OP_LOAD, 0, 0, 32'h80000000, 32'h80000000, 63, 0);
      push_word(OP_LOAD, 0, 1, 32'h7fffffff, 32'h80000000, 63, 0);
      push_word(OP_LOAD, 0, 2, 32'h7fffffff, 32'h7fffffff, 63, 0);
      push_word(OP_LOAD, 0, 3, 32'h80000000, 32'h80000000, 63, 1);
      written_upto[0] = 4;
      push_word(OP_QUERY, 0, 0, 32'h7fffffff, 32'h80000000, 0, 0);
      push_word(OP_QUERY, 0, 0, 32'h40000000, -32'sh10000000, 0, 0);
      push_word(OP_QUERY, 0, 0, 0, 5, 0, 0);
      push_word(OP_QUERY, 0, 0, 32'h80000000, 32'h7fffffff, 0, 0);
      push_word(OP_QUERY, 0, 0, 5 << 19, 3 << 19, 0, 0);
      push_word(OP_CLEAR, 0, 0, 0, 0, 0, 0);
      push_word(OP_QUERY, 0, 0, 5 << 19, 3 << 19, 0, 0);
      drain();

      // phases: no idling, sender mostly idle, no idling again, sender idle 24 percent
      random_phase(66);
      drain();
      csr_write(32'd0);
      sender_idle_pct = 85;
      random_phase(66);
      drain();
      csr_write(32'd1);
      sender_idle_pct = 0;
      random_phase(66);
      drain();
      csr_write(32'd0);
      sender_idle_pct = 24;
      random_phase(66);
      drain();

      if (errors == 0) begin
         $display("PASS point_in_polygon_hit_tracker");
      end else begin
         $display("FAIL point_in_polygon_hit_tracker");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/pip_pkg.sv
rtl/core/pip_edge_unit.sv
rtl/core/point_in_polygon_hit_tracker.sv
bench/point_in_polygon_hit_tracker_tb.sv
